// ===== rtl/segment_rectangle_intersection_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Segment rectangle intersection unit: assertion macros
// Shared property forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_RECTANGLE_INTERSECTION_UNIT_MACROS_SVH
`define SEGMENT_RECTANGLE_INTERSECTION_UNIT_MACROS_SVH

// same-cycle implication
`define SRI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sri: same-cycle check failed");

// next-cycle implication
`define SRI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sri: next-cycle check failed");

`endif

// ===== rtl/sri_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment rectangle intersection: package
// Register indexes, edge codes and the product tolerance test helpers.
// ----------------------------------------------------------------------------
package sri_pkg;

  localparam int TOL_W    = 16;
  localparam int ADDR_W   = 5;
  localparam int DIV_BITS = 4;

  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MAX_X = 3'd2,
    REG_MAX_Y = 3'd3,
    REG_TOL   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    SIDE_BOTTOM = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_TOP    = 2'd2,
    SIDE_LEFT   = 2'd3
  } side_t;

  typedef struct packed {
    logic              zero;
    logic              diff;
    logic              small_mag;
    logic [TOL_W-1:0]  ma;
    logic [TOL_W-1:0]  mb;
  } prod_pre_t;

  function automatic int div_stages(input int w);
    return (2 * w + DIV_BITS - 1) / DIV_BITS;
  endfunction

  function automatic int edge_latency(input int w);
    return div_stages(w) + 6;
  endfunction

  // sign/magnitude prep for a*b < tol
  function automatic prod_pre_t prod_prep(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    prod_pre_t p;
    logic [63:0] ma;
    logic [63:0] mb;
    ma = a[63] ? 64'(-a) : 64'(a);
    mb = b[63] ? 64'(-b) : 64'(b);
    p.zero      = (a == 64'sd0) || (b == 64'sd0);
    p.diff      = a[63] != b[63];
    p.small_mag = (ma < 64'd65536) && (mb < 64'd65536);
    p.ma        = ma[TOL_W-1:0];
    p.mb        = mb[TOL_W-1:0];
    return p;
  endfunction

  function automatic logic prod_fin(input prod_pre_t p, input logic [TOL_W-1:0] tol);
    logic res;
    if (p.zero) begin
      res = tol != '0;
    end else if (p.diff) begin
      res = 1'b1;
    end else begin
      res = p.small_mag && ((32'(p.ma) * 32'(p.mb)) < 32'(tol));
    end
    return res;
  endfunction

endpackage

// ===== rtl/sri_cfg.sv =====
// ----------------------------------------------------------------------------
// Segment rectangle intersection: register file
// Rectangle corners and product tolerance behind an APB-style port.
// ----------------------------------------------------------------------------
module sri_cfg import sri_pkg::*; #(
  parameter int W = 24,
  parameter int F = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic signed [W-1:0] rect_min_x,
  output logic signed [W-1:0] rect_min_y,
  output logic signed [W-1:0] rect_max_x,
  output logic signed [W-1:0] rect_max_y,
  output logic [TOL_W-1:0]    product_tolerance
);

  localparam longint TOL_RAW = (64'sd1 <<< (2 * F)) / 100;
  localparam logic [TOL_W-1:0] TOL_RST = (TOL_RAW > 65535) ? 16'hFFFF : TOL_W'(TOL_RAW);

  logic     wr;
  reg_idx_t idx;

  assign wr  = psel && penable && pwrite;
  assign idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_min_x        <= '0;
      rect_min_y        <= '0;
      rect_max_x        <= '0;
      rect_max_y        <= '0;
      product_tolerance <= TOL_RST;
    end else if (wr) begin
      case (idx)
        REG_MIN_X: rect_min_x        <= pwdata[W-1:0];
        REG_MIN_Y: rect_min_y        <= pwdata[W-1:0];
        REG_MAX_X: rect_max_x        <= pwdata[W-1:0];
        REG_MAX_Y: rect_max_y        <= pwdata[W-1:0];
        REG_TOL:   product_tolerance <= pwdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_X: prdata = 32'(rect_min_x);
      REG_MIN_Y: prdata = 32'(rect_min_y);
      REG_MAX_X: prdata = 32'(rect_max_x);
      REG_MAX_Y: prdata = 32'(rect_max_y);
      REG_TOL:   prdata = 32'(product_tolerance);
      default:   prdata = '0;
    endcase
  end

endmodule

// ===== rtl/sri_div.sv =====
// ----------------------------------------------------------------------------
// Segment rectangle intersection: pipelined divider
// Restoring unsigned division, four quotient bits per stage, side data
// travels alongside.
// ----------------------------------------------------------------------------
module sri_div import sri_pkg::*; #(
  parameter int W  = 24,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*W-1:0]  dividend,
  input  logic [W-1:0]    divisor,
  input  logic [SW-1:0]   side_in,
  output logic [2*W-1:0]  quot,
  output logic [W-1:0]    rem,
  output logic [SW-1:0]   side_out
);

  localparam int DS  = div_stages(W);
  localparam int DWP = DS * DIV_BITS;

  logic [W-1:0]   rem_r  [DS];
  logic [DWP-1:0] work_r [DS];
  logic [W-1:0]   den_r  [DS];
  logic [SW-1:0]  side_r [DS];

  for (genvar k = 0; k < DS; k++) begin : g_stage
    logic [W-1:0]   rem_i;
    logic [DWP-1:0] work_i;
    logic [W-1:0]   den_i;
    logic [SW-1:0]  side_i;
    logic [W-1:0]   rem_n;
    logic [DWP-1:0] work_n;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign work_i = DWP'(dividend);
      assign den_i  = divisor;
      assign side_i = side_in;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign work_i = work_r[k-1];
      assign den_i  = den_r[k-1];
      assign side_i = side_r[k-1];
    end

    always_comb begin
      logic [W:0]     t;
      logic [W-1:0]   r;
      logic [DWP-1:0] wk;
      r  = rem_i;
      wk = work_i;
      for (int b = 0; b < DIV_BITS; b++) begin
        t  = {r, wk[DWP-1]};
        wk = {wk[DWP-2:0], 1'b0};
        if (t >= {1'b0, den_i}) begin
          t     = t - {1'b0, den_i};
          wk[0] = 1'b1;
        end
        r = t[W-1:0];
      end
      rem_n  = r;
      work_n = wk;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_n;
        work_r[k] <= work_n;
        den_r[k]  <= den_i;
        side_r[k] <= side_i;
      end
    end
  end

  assign quot     = work_r[DS-1][2*W-1:0];
  assign rem      = rem_r[DS-1];
  assign side_out = side_r[DS-1];

endmodule

// ===== rtl/sri_edge.sv =====
// ----------------------------------------------------------------------------
// Segment rectangle intersection: one edge test
// Crossing of a segment with an axis-aligned edge at v = c spanning lo..hi,
// and the on-segment and on-edge product tests.
// ----------------------------------------------------------------------------
module sri_edge import sri_pkg::*; #(
  parameter int W = 24
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] a1u,
  input  logic signed [W-1:0] a1v,
  input  logic signed [W-1:0] a2u,
  input  logic signed [W-1:0] a2v,
  input  logic signed [W-1:0] c,
  input  logic signed [W-1:0] lo,
  input  logic signed [W-1:0] hi,
  input  logic [TOL_W-1:0]    tol,
  output logic                ok,
  output logic signed [W-1:0] pu
);

  // quotients at or above 2^QB can never pass the segment test
  localparam int QB = (W + 1 > 17) ? W + 1 : 17;
  localparam int PW = QB + 2;
  localparam int SW = 4 * W + 3;
  localparam longint CMAX = (64'sd1 <<< (W - 1)) - 1;
  localparam longint CMIN = -(64'sd1 <<< (W - 1));

  // stage 1: differences
  logic signed [W:0]   du1, dv1, n11, v11, v21;
  logic signed [W-1:0] a1u1, a2u1, lo1, hi1;
  logic                skip1;

  always_ff @(posedge clk) begin
    if (en) begin
      du1   <= (W+1)'(a2u) - (W+1)'(a1u);
      dv1   <= (W+1)'(a2v) - (W+1)'(a1v);
      n11   <= (W+1)'(c) - (W+1)'(a1v);
      v11   <= (W+1)'(a1v) - (W+1)'(c);
      v21   <= (W+1)'(a2v) - (W+1)'(c);
      a1u1  <= a1u;
      a2u1  <= a2u;
      lo1   <= lo;
      hi1   <= hi;
      skip1 <= (a2v == a1v) || (lo == hi);
    end
  end

  // stage 2: magnitudes
  logic [W-1:0]        mn2, mdu2, mdv2;
  logic                neg2, skip2;
  prod_pre_t           vpre2;
  logic signed [W-1:0] a1u2, a2u2, lo2, hi2;

  always_ff @(posedge clk) begin
    if (en) begin
      mn2   <= W'(n11[W] ? -n11 : n11);
      mdu2  <= W'(du1[W] ? -du1 : du1);
      mdv2  <= W'(dv1[W] ? -dv1 : dv1);
      neg2  <= n11[W] ^ du1[W] ^ dv1[W];
      vpre2 <= prod_prep(64'(v11), 64'(v21));
      skip2 <= skip1;
      a1u2  <= a1u1;
      a2u2  <= a2u1;
      lo2   <= lo1;
      hi2   <= hi1;
    end
  end

  // stage 3: numerator product
  logic [2*W-1:0] num3;
  logic [W-1:0]   den3;
  logic [SW-1:0]  side3;

  always_ff @(posedge clk) begin
    if (en) begin
      num3  <= (2*W)'(mn2) * (2*W)'(mdu2);
      den3  <= mdv2;
      side3 <= {a1u2, a2u2, lo2, hi2, neg2, skip2, prod_fin(vpre2, tol)};
    end
  end

  logic [2*W-1:0] quot4;
  logic [W-1:0]   rem4;
  logic [SW-1:0]  side4;

  sri_div #(.W(W), .SW(SW)) u_div (
    .clk      (clk),
    .en       (en),
    .dividend (num3),
    .divisor  (den3),
    .side_in  (side3),
    .quot     (quot4),
    .rem      (rem4),
    .side_out (side4)
  );

  // stage 4: signed quotient and crossing coordinate
  logic signed [W-1:0]  a1u4, a2u4, lo4, hi4;
  logic                 neg4, skip4, vok4, big4, rok4;
  logic [PW-1:0]        qv4;
  logic signed [PW-1:0] q4, pu4;

  assign {a1u4, a2u4, lo4, hi4, neg4, skip4, vok4} = side4;
  assign big4 = (quot4 >> QB) != '0;
  assign qv4  = big4 ? '0 : PW'(quot4);
  assign q4   = neg4 ? -$signed(qv4) : $signed(qv4);
  assign pu4  = PW'(a1u4) + q4;
  assign rok4 = 64'(rem4) < 64'(tol);

  logic signed [PW-1:0] q5, pu5;
  logic signed [W-1:0]  a2u5, lo5, hi5;
  logic                 okp5;

  always_ff @(posedge clk) begin
    if (en) begin
      q5   <= q4;
      pu5  <= pu4;
      a2u5 <= a2u4;
      lo5  <= lo4;
      hi5  <= hi4;
      okp5 <= !skip4 && !big4 && vok4 && rok4;
    end
  end

  // stage 5: distances to the endpoints, saturation
  logic signed [PW:0] d15, d25, e15, e25;
  prod_pre_t          spre6, epre6;
  logic               okp6;
  logic signed [W-1:0] pus6;

  assign d15 = -(PW+1)'(q5);
  assign d25 = (PW+1)'(a2u5) - (PW+1)'(pu5);
  assign e15 = (PW+1)'(lo5) - (PW+1)'(pu5);
  assign e25 = (PW+1)'(hi5) - (PW+1)'(pu5);

  always_ff @(posedge clk) begin
    if (en) begin
      spre6 <= prod_prep(64'(d15), 64'(d25));
      epre6 <= prod_prep(64'(e15), 64'(e25));
      okp6  <= okp5;
      if (64'(pu5) > CMAX) begin
        pus6 <= W'(CMAX);
      end else if (64'(pu5) < CMIN) begin
        pus6 <= W'(CMIN);
      end else begin
        pus6 <= W'(pu5);
      end
    end
  end

  // stage 6: product tests
  always_ff @(posedge clk) begin
    if (en) begin
      ok <= okp6 && prod_fin(spre6, tol) && prod_fin(epre6, tol);
      pu <= pus6;
    end
  end

endmodule

// ===== rtl/segment_rectangle_intersection_unit.sv =====
// ----------------------------------------------------------------------------
// Segment rectangle intersection unit
// Tests each segment against the bottom, right, top and left edges of the
// configured rectangle and returns the first crossing found.
//
// Channel  Dir  Fields (low bit up)
// s_       in   tdata: start_x, start_y, end_x, end_y
// m_       out  tdata: hit_x, hit_y; tuser: hit, edge_index
// apb      in   rect_min_x, rect_min_y, rect_max_x, rect_max_y, product_tolerance
//
// One request per cycle while the result is not stalled; the divider
// takes four quotient bits per stage.
// Synchronous reset clears the valid line and loads register defaults.
// A stalled result freezes the whole pipeline; s_tready drops with it.
// ----------------------------------------------------------------------------
`include "segment_rectangle_intersection_unit_macros.svh"

module segment_rectangle_intersection_unit import sri_pkg::*; #(
  parameter int COORD_WIDTH   = 24,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // start_x, start_y, end_x, end_y
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // hit_x, hit_y
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]     m_tdata,
  // hit, edge_index
  output logic [2:0]                             m_tuser,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [ADDR_W-1:0]                      paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  localparam int W   = COORD_WIDTH;
  localparam int LAT = edge_latency(W);
  localparam int ODW = ((2*W+7)/8)*8;

  logic signed [W-1:0] rect_min_x, rect_min_y, rect_max_x, rect_max_y;
  logic [TOL_W-1:0]    product_tolerance;

  assign pready = 1'b1;

  sri_cfg #(.W(W), .F(FRACTION_BITS)) u_cfg (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .rect_min_x        (rect_min_x),
    .rect_min_y        (rect_min_y),
    .rect_max_x        (rect_max_x),
    .rect_max_y        (rect_max_y),
    .product_tolerance (product_tolerance)
  );

  logic                en;
  logic signed [W-1:0] sx, sy, ex, ey;
  logic [LAT-1:0]      vld;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign sx = s_tdata[W-1:0];
  assign sy = s_tdata[2*W-1:W];
  assign ex = s_tdata[3*W-1:2*W];
  assign ey = s_tdata[4*W-1:3*W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  logic                ok   [4];
  logic signed [W-1:0] cpos [4];

  sri_edge #(.W(W)) u_bottom (
    .clk(clk), .en(en), .a1u(sx), .a1v(sy), .a2u(ex), .a2v(ey),
    .c(rect_min_y), .lo(rect_min_x), .hi(rect_max_x), .tol(product_tolerance),
    .ok(ok[0]), .pu(cpos[0])
  );

  sri_edge #(.W(W)) u_right (
    .clk(clk), .en(en), .a1u(sy), .a1v(sx), .a2u(ey), .a2v(ex),
    .c(rect_max_x), .lo(rect_min_y), .hi(rect_max_y), .tol(product_tolerance),
    .ok(ok[1]), .pu(cpos[1])
  );

  sri_edge #(.W(W)) u_top (
    .clk(clk), .en(en), .a1u(sx), .a1v(sy), .a2u(ex), .a2v(ey),
    .c(rect_max_y), .lo(rect_max_x), .hi(rect_min_x), .tol(product_tolerance),
    .ok(ok[2]), .pu(cpos[2])
  );

  sri_edge #(.W(W)) u_left (
    .clk(clk), .en(en), .a1u(sy), .a1v(sx), .a2u(ey), .a2v(ex),
    .c(rect_min_x), .lo(rect_max_y), .hi(rect_min_y), .tol(product_tolerance),
    .ok(ok[3]), .pu(cpos[3])
  );

  logic                hit_c;
  logic signed [W-1:0] hx_c, hy_c;
  side_t               side_c;

  always_comb begin
    hit_c  = 1'b1;
    hx_c   = '0;
    hy_c   = '0;
    side_c = SIDE_BOTTOM;
    if (ok[0]) begin
      hx_c = cpos[0];
      hy_c = rect_min_y;
    end else if (ok[1]) begin
      hx_c   = rect_max_x;
      hy_c   = cpos[1];
      side_c = SIDE_RIGHT;
    end else if (ok[2]) begin
      hx_c   = cpos[2];
      hy_c   = rect_max_y;
      side_c = SIDE_TOP;
    end else if (ok[3]) begin
      hx_c   = rect_min_x;
      hy_c   = cpos[3];
      side_c = SIDE_LEFT;
    end else begin
      hit_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= ODW'({hy_c, hx_c});
      m_tuser <= {side_c, hit_c};
    end
  end

  `SRI_ASSERT_IMPL(a_nohit_zero, m_tvalid && !m_tuser[0], m_tdata == '0 && m_tuser[2:1] == SIDE_BOTTOM)
  `SRI_ASSERT_NEXT(a_stall_freeze, !s_tready, $stable(vld))
  `SRI_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld[0])

endmodule

// ===== tb/sv/segment_rectangle_intersection_unit_test.sv =====
// ----------------------------------------------------------------------------
// Segment rectangle intersection unit: testbench
// Streams segments through the unit under several rectangle and tolerance
// settings, predicts every result in a behavioral model of the edge tests and
// compares each returned result field by field, with random stalls on both
// sides.
// ----------------------------------------------------------------------------
module segment_rectangle_intersection_unit_test;
  import sri_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW        = 24;
  localparam int LATENCY   = 19;
  localparam int LIMIT     = 600000;
  localparam int N_PHASES  = 9;
  localparam int PHASE_LEN = 140;

  typedef struct {
    logic signed [CW-1:0] sx, sy, ex, ey;
  } segment_t;

  typedef struct {
    logic                 hit;
    logic signed [CW-1:0] px, py;
    side_t                side;
  } crossing_t;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
  logic [95:0] s_tdata;
  logic [47:0] m_tdata;
  logic [2:0]  m_tuser;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;

  segment_t  seg_pending[$];
  crossing_t crossing_due[$];
  segment_t  seg_cur;
  longint    rect_lo_x, rect_lo_y, rect_hi_x, rect_hi_y;
  longint unsigned tol_cur;
  int  errors = 0, n_sent = 0, n_checked = 0, n_hits = 0, cycles = 0;
  int  s_gap = 0, m_gap = 0;
  bit  quiet = 0, taken = 0;

  // start_x, start_y, end_x, end_y
  assign s_tdata = {seg_cur.ey, seg_cur.ex, seg_cur.sy, seg_cur.sx};

  segment_rectangle_intersection_unit i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
    .m_tdata,  // hit_x, hit_y
    .m_tuser,  // hit, edge_index
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk = ~clk;

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint clamp_diff(longint d);
    if (d > 64'sd4294967295) return 64'sd4294967295;
    if (d < -64'sd4294967295) return -64'sd4294967295;
    return d;
  endfunction

  function automatic bit prod_below(longint a, longint b, longint unsigned tol);
    a = clamp_diff(a);
    b = clamp_diff(b);
    if (a == 0 || b == 0) return tol > 0;
    if ((a < 0) != (b < 0)) return 1;
    return magn(a) * magn(b) < tol;
  endfunction

  // edge at v = c, spanning u from lo to hi
  function automatic bit edge_crossing(longint a1u, longint a1v, longint a2u, longint a2v,
                                       longint c, longint lo, longint hi,
                                       longint unsigned tol, output longint pu);
    longint du, dv, n1, q;
    longint unsigned num, den, qm, rm;
    bit neg;
    du = a2u - a1u;
    dv = a2v - a1v;
    n1 = c - a1v;
    pu = 0;
    if (dv == 0 || lo == hi) return 0;
    num = magn(n1) * magn(du);
    den = magn(dv);
    qm = num / den;
    rm = num % den;
    if (qm > 64'd8589934592) qm = 64'd8589934592;
    neg = ((n1 < 0) != (du < 0)) != (dv < 0);
    q = neg ? -longint'(qm) : longint'(qm);
    pu = a1u + q;
    return rm < tol && prod_below(a1u - pu, a2u - pu, tol)
        && prod_below(a1v - c, a2v - c, tol)
        && prod_below(lo - pu, hi - pu, tol) && prod_below(0, 0, tol);
  endfunction

  function automatic logic signed [CW-1:0] saturate(longint v);
    if (v > 64'sd8388607) v = 8388607;
    if (v < -64'sd8388608) v = -8388608;
    return v[CW-1:0];
  endfunction

  function automatic crossing_t first_crossing(segment_t s);
    crossing_t r;
    longint sx, sy, ex, ey, t;
    sx = s.sx; sy = s.sy; ex = s.ex; ey = s.ey;
    r = '{hit: 0, px: '0, py: '0, side: SIDE_BOTTOM};
    if (edge_crossing(sx, sy, ex, ey, rect_lo_y, rect_lo_x, rect_hi_x, tol_cur, t))
      r = '{1, saturate(t), saturate(rect_lo_y), SIDE_BOTTOM};
    else if (edge_crossing(sy, sx, ey, ex, rect_hi_x, rect_lo_y, rect_hi_y, tol_cur, t))
      r = '{1, saturate(rect_hi_x), saturate(t), SIDE_RIGHT};
    else if (edge_crossing(sx, sy, ex, ey, rect_hi_y, rect_hi_x, rect_lo_x, tol_cur, t))
      r = '{1, saturate(t), saturate(rect_hi_y), SIDE_TOP};
    else if (edge_crossing(sy, sx, ey, ex, rect_lo_x, rect_hi_y, rect_lo_y, tol_cur, t))
      r = '{1, saturate(rect_lo_x), saturate(t), SIDE_LEFT};
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at result %0d: %s got %0d expected %0d", n_checked, what, got, want);
    errors++;
  endtask

  task automatic apb_write(reg_idx_t idx, longint value);
    @(negedge clk);
    psel = 1; pwrite = 1; penable = 0;
    paddr = ADDR_W'(4 * int'(idx));
    pwdata = 32'(value);
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    case (idx)
      REG_MIN_X: rect_lo_x = longint'(signed'(value[CW-1:0]));
      REG_MIN_Y: rect_lo_y = longint'(signed'(value[CW-1:0]));
      REG_MAX_X: rect_hi_x = longint'(signed'(value[CW-1:0]));
      REG_MAX_Y: rect_hi_y = longint'(signed'(value[CW-1:0]));
      default:   tol_cur = value & 64'hFFFF;
    endcase
  endtask

  task automatic set_rect(longint x0, longint y0, longint x1, longint y1, longint tol);
    apb_write(REG_MIN_X, x0);
    apb_write(REG_MIN_Y, y0);
    apb_write(REG_MAX_X, x1);
    apb_write(REG_MAX_Y, y1);
    apb_write(REG_TOL, tol);
  endtask

  task automatic add_seg(longint sx, longint sy, longint ex, longint ey);
    segment_t s;
    s.sx = sx[CW-1:0]; s.sy = sy[CW-1:0]; s.ex = ex[CW-1:0]; s.ey = ey[CW-1:0];
    seg_pending.push_back(s);
  endtask

  function automatic longint near(longint c, int span);
    return c + longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic add_random_seg();
    int mode;
    longint cx, cy;
    mode = $urandom_range(0, 9);
    cx = near((rect_lo_x + rect_hi_x) / 2, 200);
    cy = near((rect_lo_y + rect_hi_y) / 2, 200);
    if (mode < 2) begin
      add_seg($urandom, $urandom, $urandom, $urandom);
    end else if (mode < 4) begin
      // axis aligned through the rectangle
      if ($urandom_range(0, 1))
        add_seg(cx, near(cy, 3000), cx, near(cy, 3000));
      else
        add_seg(near(cx, 3000), cy, near(cx, 3000), cy);
    end else if (mode < 6) begin
      add_seg(near(cx, 40), near(cy, 40), near(cx, 3000), near(cy, 3000));
    end else begin
      add_seg(near(cx, 2500), near(cy, 2500), near(cx, 2500), near(cy, 2500));
    end
  endtask

  task automatic wait_idle();
    while (seg_pending.size() != 0 || s_tvalid || crossing_due.size() != 0)
      @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  // requests accepted, expectations queued, results checked
  always @(posedge clk) begin
    cycles++;
    if (!rst && s_tvalid && s_tready) begin
      crossing_due.push_back(first_crossing(seg_cur));
      n_sent++;
      taken = 1;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (crossing_due.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        crossing_t w;
        w = crossing_due.pop_front();
        if (m_tuser[0] !== w.hit) report_mismatch("hit", m_tuser[0], w.hit);
        if (m_tdata[23:0] !== w.px)
          report_mismatch("hit_x", signed'(m_tdata[23:0]), w.px);
        if (m_tdata[47:24] !== w.py)
          report_mismatch("hit_y", signed'(m_tdata[47:24]), w.py);
        if (m_tuser[2:1] !== w.side) report_mismatch("edge_index", m_tuser[2:1], w.side);
        n_hits += w.hit;
      end
      n_checked++;
    end
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (s_gap > 0) s_gap--;
    else if (!quiet && $urandom_range(0, 12) == 0) s_gap = $urandom_range(1, 10);
    if (!s_tvalid || taken) begin
      taken = 0;
      if (s_gap == 0 && seg_pending.size() != 0 && !rst) begin
        seg_cur = seg_pending.pop_front();
        s_tvalid = 1;
      end else begin
        s_tvalid = 0;
      end
    end
    if (m_gap > 0) m_gap--;
    else if (!quiet && $urandom_range(0, 12) == 0) m_gap = $urandom_range(1, 10);
    m_tready = !rst && m_gap == 0;
  end

  initial begin
    seg_cur = '{default: '0};
    rect_lo_x = 0; rect_lo_y = 0; rect_hi_x = 0; rect_hi_y = 0; tol_cur = 655;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // reset rectangle is a point: no edge can be hit
    add_seg(-100, -100, 100, 100);
    wait_idle();
    set_rect(-1000, -500, 1000, 500, 655);
    add_seg(0, -1000, 0, 0);
    add_seg(2000, 0, 0, 0);
    add_seg(0, 1000, 0, 0);
    add_seg(-2000, 100, 0, 100);
    add_seg(0, 0, 10, 10);
    add_seg(7, 7, 7, 7);
    add_seg(-2000, -1000, 2000, 1000);
    add_seg(-8388608, -8388608, 8388607, 8388607);
    add_seg(8388607, -8388608, -8388608, 8388607);
    add_seg(-1000, -2000, -1000, 2000);
    add_seg(300, -501, 300, -499);
    add_seg(-3000, 600, 3000, 600);
    add_seg(-1, -1, -1, -1);
    wait_idle();
    set_rect(1000, 500, -1000, -500, 0);
    add_seg(0, -1000, 0, 0);
    add_seg(0, 0, 10, 10);
    wait_idle();
    set_rect(-1000, 300, 1000, 300, 65535);
    add_seg(0, -1000, 0, 1000);
    add_seg(-2000, 300, 2000, 300);
    wait_idle();
    set_rect(-8388608, -8388608, 8388607, 8388607, 655);
    add_seg(0, 0, 0, 8388607);
    add_seg(-8388608, 0, 8388607, 5);
    add_seg(8388607, 8388607, -8388608, -8388608);
    wait_idle();
    for (int ph = 0; ph < N_PHASES; ph++) begin
      longint x0, y0, tol;
      x0 = longint'($urandom_range(0, 4000)) - 2000;
      y0 = longint'($urandom_range(0, 4000)) - 2000;
      case ($urandom_range(0, 5))
        0: tol = 0;
        1: tol = 65535;
        2: tol = 655;
        default: tol = $urandom_range(0, 65535);
      endcase
      if (ph == N_PHASES - 1) quiet = 1;
      if (ph % 3 == 2)
        set_rect(x0 + $urandom_range(0, 3000), y0 + $urandom_range(0, 3000), x0, y0, tol);
      else
        set_rect(x0, y0, x0 + $urandom_range(0, 3000), y0 + $urandom_range(0, 3000), tol);
      repeat (PHASE_LEN) add_random_seg();
      wait_idle();
    end
    $display("%0d segments sent over several rectangle settings", n_sent);
    $display("%0d results checked, %0d of them edge hits", n_checked, n_hits);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
